// ===== hdl/lfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfd_pkg: shared types and constants of the link frame deframer
// Holds the request and result payloads, the queue entry, config and CRC step.
// ----------------------------------------------------------------------------
`default_nettype none

package lfd_pkg;

	localparam int HEADER_BYTES     = 9;
	localparam int SEQ_WINDOW_DEPTH = 8;
	localparam int SEQ_IDX_W        = (SEQ_WINDOW_DEPTH > 1) ? $clog2(SEQ_WINDOW_DEPTH) : 1;
	localparam int SEQ_CNT_W        = $clog2(SEQ_WINDOW_DEPTH + 1);
	localparam int RESCAN_BYTES     = HEADER_BYTES - 2;
	localparam logic [16:0] TRAILER_BYTES = 17'd4;
	localparam logic [15:0] BACKWARD_LIMIT = 16'h8000;
	localparam logic [7:0]  GAP_MAX = 8'd255;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

	// request function codes
	localparam logic [1:0] FUNC_DATA    = 2'd0;
	localparam logic [1:0] FUNC_SESSION = 2'd1;
	localparam logic [1:0] FUNC_RESYNC  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_FRAME   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// error codes
	localparam logic [1:0] ERR_VERSION = 2'd0;
	localparam logic [1:0] ERR_LENGTH  = 2'd1;
	localparam logic [1:0] ERR_CRC     = 2'd2;

	// config register indexes
	localparam logic [2:0] REG_MAGIC_FIRST  = 3'd0;
	localparam logic [2:0] REG_MAGIC_SECOND = 3'd1;
	localparam logic [2:0] REG_VERSION      = 3'd2;
	localparam logic [2:0] REG_MAX_LEN      = 3'd3;
	localparam logic [2:0] REG_DATA_TYPE    = 3'd4;
	localparam logic [2:0] REG_JUMP_LIMIT   = 3'd5;

	typedef enum logic [1:0] {
		OP_PAYLOAD,
		OP_ERROR,
		OP_FRAME,
		OP_SESSION
	} op_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] link_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [1:0]  error_code;
		logic [7:0]  frame_version;
		logic [7:0]  frame_type;
		logic [7:0]  frame_flags;
		logic [15:0] frame_seq;
		logic [15:0] frame_len;
		logic        dup_flag;
		logic [7:0]  seq_gap;
	} out_item_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic [1:0]  err;
		logic [7:0]  version;
		logic [7:0]  ftype;
		logic [7:0]  flags;
		logic [15:0] seq;
		logic [15:0] len;
	} q_item_t;

	typedef struct packed {
		logic [7:0]  magic_first;
		logic [7:0]  magic_second;
		logic [7:0]  protocol_version;
		logic [15:0] max_payload_len;
		logic [7:0]  data_chunk_type;
		logic [14:0] wild_jump_limit;
	} cfg_t;

	// one byte of the reflected crc-32
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/lfd_front.sv =====
// ----------------------------------------------------------------------------
// lfd_front: byte parser of the link frame deframer
// Hunts for magic, collects and checks the header, passes payload, checks crc.
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  lfd_pkg::in_item_t   in_data,
	input  lfd_pkg::cfg_t       cfg,
	input  wire                 q_full,
	output logic                q_push,
	output lfd_pkg::q_item_t    q_item
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_PAYLOAD,
		PH_TRAILER
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        saw_q, saw_d;
	logic [16:0] cnt_q, cnt_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] trl_q, trl_d;
	logic [31:0] magic_crc_q;
	logic [7:0]  hdr_q [lfd_pkg::HEADER_BYTES];
	logic [7:0]  rs_buf_q [lfd_pkg::RESCAN_BYTES];
	logic [2:0]  rs_left_q;
	logic [2:0]  rs_idx_q;
	logic        busy;
	logic        acc;
	logic        go;
	logic [7:0]  b;
	logic        hdr_we;
	logic        rs_start;
	logic [15:0] len_cur;
	logic [15:0] len_new;
	logic [16:0] pay_end;
	logic [1:0]  pos;

	assign busy     = (rs_left_q != 3'd0);
	assign in_ready = !busy && !q_full;
	assign acc      = in_valid && in_ready;
	assign go       = busy || (acc && (in_data.func == lfd_pkg::FUNC_DATA));
	assign b        = busy ? rs_buf_q[rs_idx_q] : in_data.link_byte;
	assign len_cur  = {hdr_q[8], hdr_q[7]};
	assign len_new  = {b, hdr_q[7]};
	assign pay_end  = {1'b0, len_cur} + 17'(lfd_pkg::HEADER_BYTES);
	assign pos      = 2'(cnt_q - pay_end);

	// parser next state
	always_comb begin
		phase_d  = phase_q;
		saw_d    = saw_q;
		cnt_d    = cnt_q;
		crc_d    = crc_q;
		trl_d    = trl_q;
		hdr_we   = 1'b0;
		rs_start = 1'b0;
		q_push   = 1'b0;
		q_item   = '0;
		if (acc && (in_data.func == lfd_pkg::FUNC_SESSION)) begin
			q_push      = 1'b1;
			q_item.op   = lfd_pkg::OP_SESSION;
		end
		if (acc && (in_data.func == lfd_pkg::FUNC_RESYNC)) begin
			phase_d = PH_HUNT;
			saw_d   = 1'b0;
			cnt_d   = '0;
		end
		if (go) begin
			case (phase_q)
				PH_HUNT: begin
					if (b == cfg.magic_first) begin
						saw_d = 1'b1;
					end else if (saw_q && (b == cfg.magic_second)) begin
						crc_d   = magic_crc_q;
						cnt_d   = 17'd2;
						saw_d   = 1'b0;
						phase_d = PH_HEADER;
					end else begin
						saw_d = 1'b0;
					end
				end
				PH_HEADER: begin
					if (cnt_q >= 17'(lfd_pkg::HEADER_BYTES)) begin
						phase_d = PH_HUNT;
						saw_d   = 1'b0;
						cnt_d   = '0;
					end else begin
						hdr_we = 1'b1;
						cnt_d  = cnt_q + 17'd1;
						crc_d  = lfd_pkg::crc_byte(crc_q, b);
						if (cnt_q == 17'(lfd_pkg::HEADER_BYTES - 1)) begin
							if ((hdr_q[2] != cfg.protocol_version) ||
							    (len_new > cfg.max_payload_len)) begin
								q_push      = 1'b1;
								q_item.op   = lfd_pkg::OP_ERROR;
								q_item.err  = (hdr_q[2] != cfg.protocol_version) ?
								              lfd_pkg::ERR_VERSION : lfd_pkg::ERR_LENGTH;
								rs_start    = 1'b1;
								phase_d     = PH_HUNT;
								saw_d       = 1'b0;
								cnt_d       = '0;
							end else begin
								trl_d   = '0;
								phase_d = (len_new != 16'd0) ? PH_PAYLOAD : PH_TRAILER;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					crc_d       = lfd_pkg::crc_byte(crc_q, b);
					cnt_d       = cnt_q + 17'd1;
					if ((cnt_q + 17'd1) >= pay_end) begin
						phase_d = PH_TRAILER;
					end
					q_push      = 1'b1;
					q_item.op   = lfd_pkg::OP_PAYLOAD;
					q_item.data = b;
				end
				default: begin
					trl_d = trl_q | ({24'd0, b} << {pos, 3'd0});
					cnt_d = cnt_q + 17'd1;
					if ((cnt_q + 17'd1) >= (pay_end + lfd_pkg::TRAILER_BYTES)) begin
						q_push = 1'b1;
						if ((crc_q ^ lfd_pkg::CRC_ONES) != trl_d) begin
							q_item.op  = lfd_pkg::OP_ERROR;
							q_item.err = lfd_pkg::ERR_CRC;
						end else begin
							q_item.op      = lfd_pkg::OP_FRAME;
							q_item.version = hdr_q[2];
							q_item.ftype   = hdr_q[3];
							q_item.flags   = hdr_q[4];
							q_item.seq     = {hdr_q[6], hdr_q[5]};
							q_item.len     = len_cur;
						end
						phase_d = PH_HUNT;
						saw_d   = 1'b0;
						cnt_d   = '0;
					end
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			saw_q       <= 1'b0;
			cnt_q       <= '0;
			crc_q       <= lfd_pkg::CRC_ONES;
			trl_q       <= '0;
			rs_left_q   <= '0;
			rs_idx_q    <= '0;
			magic_crc_q <= '0;
		end else begin
			phase_q     <= phase_d;
			saw_q       <= saw_d;
			cnt_q       <= cnt_d;
			crc_q       <= crc_d;
			trl_q       <= trl_d;
			magic_crc_q <= lfd_pkg::crc_byte(lfd_pkg::crc_byte(lfd_pkg::CRC_ONES,
			               cfg.magic_first), cfg.magic_second);
			if (rs_start) begin
				rs_left_q <= 3'(lfd_pkg::RESCAN_BYTES);
				rs_idx_q  <= '0;
			end else if (busy) begin
				rs_left_q <= rs_left_q - 3'd1;
				rs_idx_q  <= rs_idx_q + 3'd1;
			end
		end
	end

	// header bytes and rescan copy
	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_q[cnt_q[3:0]] <= b;
		end
		if (rs_start) begin
			for (int i = 0; i < lfd_pkg::RESCAN_BYTES - 1; i++) begin
				rs_buf_q[i] <= hdr_q[i + 2];
			end
			rs_buf_q[lfd_pkg::RESCAN_BYTES - 1] <= b;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lfd_queue.sv =====
// ----------------------------------------------------------------------------
// lfd_queue: short queue between parser and sequence tracker
// Four entries, one push and one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  lfd_pkg::q_item_t    push_item,
	output logic                full,
	input  wire                 pop,
	output logic                head_valid,
	output lfd_pkg::q_item_t    head_item
);

	lfd_pkg::q_item_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign full       = (cnt_q == 3'd4);
	assign head_valid = (cnt_q != 3'd0);
	assign head_item  = mem_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lfd_back.sv =====
// ----------------------------------------------------------------------------
// lfd_back: sequence tracker and result register
// Flags duplicates from a window of recent sequence numbers and gaps from the previous one.
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lfd_pkg::cfg_t       cfg,
	input  wire                 head_valid,
	input  lfd_pkg::q_item_t    head_item,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output lfd_pkg::out_item_t  out_data
);

	logic [15:0] recent_q [lfd_pkg::SEQ_WINDOW_DEPTH];
	logic [lfd_pkg::SEQ_CNT_W-1:0] rcnt_q;
	logic [lfd_pkg::SEQ_IDX_W-1:0] rnext_q;
	logic        have_prev_q;
	logic [15:0] prev_q;
	logic        out_valid_q;
	lfd_pkg::out_item_t out_q;

	logic        seen;
	logic        dup;
	logic [15:0] diff;
	logic        record;
	logic        wild;
	logic [7:0]  gap;
	logic [lfd_pkg::SEQ_IDX_W-1:0] wr_idx;
	lfd_pkg::out_item_t out_d;

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign diff      = head_item.seq - prev_q;

	// window lookup and gap
	always_comb begin
		seen = 1'b0;
		for (int i = 0; i < lfd_pkg::SEQ_WINDOW_DEPTH; i++) begin
			if ((lfd_pkg::SEQ_CNT_W'(i) < rcnt_q) && (recent_q[i] == head_item.seq)) begin
				seen = 1'b1;
			end
		end
		dup    = seen && (head_item.ftype != cfg.data_chunk_type);
		record = !dup;
		wild   = 1'b0;
		gap    = '0;
		if (!dup && have_prev_q) begin
			if ((diff == 16'd0) || (diff > lfd_pkg::BACKWARD_LIMIT)) begin
				record = 1'b0;
			end else if (diff > {1'b0, cfg.wild_jump_limit}) begin
				wild = 1'b1;
			end else if (diff > 16'd1) begin
				gap = ((diff - 16'd1) > 16'(lfd_pkg::GAP_MAX)) ? lfd_pkg::GAP_MAX :
				      8'(diff - 16'd1);
			end
		end
		wr_idx = wild ? '0 : rnext_q;
	end

	// result payload for the head entry
	always_comb begin
		out_d = '0;
		case (head_item.op)
			lfd_pkg::OP_PAYLOAD: begin
				out_d.kind         = lfd_pkg::KIND_PAYLOAD;
				out_d.payload_byte = head_item.data;
			end
			lfd_pkg::OP_ERROR: begin
				out_d.kind       = lfd_pkg::KIND_ERROR;
				out_d.error_code = head_item.err;
			end
			lfd_pkg::OP_FRAME: begin
				out_d.kind          = lfd_pkg::KIND_FRAME;
				out_d.frame_version = head_item.version;
				out_d.frame_type    = head_item.ftype;
				out_d.frame_flags   = head_item.flags;
				out_d.frame_seq     = head_item.seq;
				out_d.frame_len     = head_item.len;
				out_d.dup_flag      = dup;
				out_d.seq_gap       = gap;
			end
			default: begin
			end
		endcase
	end

	// tracking state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q      <= '0;
			rnext_q     <= '0;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= (head_item.op != lfd_pkg::OP_SESSION);
			case (head_item.op)
				lfd_pkg::OP_SESSION: begin
					rcnt_q      <= '0;
					rnext_q     <= '0;
					have_prev_q <= 1'b0;
					prev_q      <= '0;
				end
				lfd_pkg::OP_FRAME: begin
					if (record) begin
						have_prev_q <= 1'b1;
						prev_q      <= head_item.seq;
						rnext_q     <= (wr_idx == lfd_pkg::SEQ_IDX_W'(lfd_pkg::SEQ_WINDOW_DEPTH - 1))
						               ? '0 : wr_idx + lfd_pkg::SEQ_IDX_W'(1);
						if (wild) begin
							rcnt_q <= lfd_pkg::SEQ_CNT_W'(1);
						end else if (rcnt_q < lfd_pkg::SEQ_CNT_W'(lfd_pkg::SEQ_WINDOW_DEPTH)) begin
							rcnt_q <= rcnt_q + lfd_pkg::SEQ_CNT_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// window entries and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if ((head_item.op == lfd_pkg::OP_FRAME) && record) begin
				recent_q[wr_idx] <= head_item.seq;
			end
			out_q <= out_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/link_frame_deframer_seq_tracker.sv =====
// ----------------------------------------------------------------------------
// link_frame_deframer_seq_tracker: link byte deframer with sequence tracking
// Parser front end, four-entry queue, sequence tracker with result register.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready: a link byte, a new-session command or a
// resync command. Results leave on out_valid/out_ready: a tentative payload
// byte, a verified frame with duplicate and gap flags, or an error. One request
// is taken per cycle while in_ready is high. A result is held in a queue entry
// and then in the result register. A header rejected for version or length
// holds in_ready low while the parser rescans the seven bytes after the magic,
// one per cycle. When the receiver stalls, results collect in the queue and
// the result register; in_ready falls once the four queue entries are full.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must do so only while the block is idle, which the block does not enforce.
// Reset puts the parser in hunt, clears the queue, the result register and
// the sequence window, and loads the default register values.
`default_nettype none

module link_frame_deframer_seq_tracker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  lfd_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output lfd_pkg::out_item_t  out_data,
	input  wire                 cfg_we,
	input  wire  [2:0]          cfg_index,
	input  wire  [15:0]         cfg_wdata
);

	lfd_pkg::cfg_t    cfg_q;
	logic             q_full;
	logic             q_push;
	lfd_pkg::q_item_t q_item;
	logic             q_pop;
	logic             head_valid;
	lfd_pkg::q_item_t head_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_first      <= 8'd66;
			cfg_q.magic_second     <= 8'd75;
			cfg_q.protocol_version <= 8'd1;
			cfg_q.max_payload_len  <= 16'd1024;
			cfg_q.data_chunk_type  <= 8'd0;
			cfg_q.wild_jump_limit  <= 15'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				lfd_pkg::REG_MAGIC_FIRST:  cfg_q.magic_first      <= cfg_wdata[7:0];
				lfd_pkg::REG_MAGIC_SECOND: cfg_q.magic_second     <= cfg_wdata[7:0];
				lfd_pkg::REG_VERSION:      cfg_q.protocol_version <= cfg_wdata[7:0];
				lfd_pkg::REG_MAX_LEN:      cfg_q.max_payload_len  <= cfg_wdata;
				lfd_pkg::REG_DATA_TYPE:    cfg_q.data_chunk_type  <= cfg_wdata[7:0];
				lfd_pkg::REG_JUMP_LIMIT:   cfg_q.wild_jump_limit  <= cfg_wdata[14:0];
				default: begin
				end
			endcase
		end
	end

	lfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_item)
	);

	lfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	lfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

// ===== sim/lfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_checker: result predictor and comparator for the link frame deframer
// Follows every accepted request, computes the expected result and compares
// each accepted result field by field against the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_ready,
	input  lfd_pkg::in_item_t   in_data,
	input  wire                 out_valid,
	input  wire                 out_ready,
	input  lfd_pkg::out_item_t  out_data,
	input  wire                 cfg_we,
	input  wire  [2:0]          cfg_index,
	input  wire  [15:0]         cfg_wdata,
	output int                  fail_count,
	output int                  pending
);

	typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_PAYLOAD, PH_TRAILER} phase_t;

	lfd_pkg::cfg_t      regs;
	phase_t             phase;
	logic               got_first;
	logic [7:0]         hdr [lfd_pkg::HEADER_BYTES];
	int unsigned        nbytes;
	logic [31:0]        crc;
	logic [31:0]        trailer;
	logic               seq_valid;
	logic [15:0]        prev_seq;
	logic [15:0]        window [lfd_pkg::SEQ_WINDOW_DEPTH];
	int unsigned        win_count;
	int unsigned        win_next;
	lfd_pkg::out_item_t expected_results [$];

	assign pending = expected_results.size();

	// crc-32 reflected, one byte
	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
		return r;
	endfunction

	task automatic framing_clear();
		phase = PH_HUNT;
		got_first = 1'b0;
		nbytes = 0;
	endtask

	task automatic hunt(input logic [7:0] b);
		if (b == regs.magic_first) begin
			got_first = 1'b1;
		end else if (got_first && b == regs.magic_second) begin
			hdr[0] = regs.magic_first;
			hdr[1] = regs.magic_second;
			crc = crc_step(crc_step(32'hFFFFFFFF, regs.magic_first), regs.magic_second);
			nbytes = 2;
			got_first = 1'b0;
			phase = PH_HEADER;
		end else begin
			got_first = 1'b0;
		end
	endtask

	// duplicate and gap tracking for a frame whose crc matched
	task automatic track_frame(inout lfd_pkg::out_item_t r);
		logic [15:0] seq, diff;
		logic        dup, rec;
		seq = {hdr[6], hdr[5]};
		dup = 1'b0;
		rec = 1'b1;
		for (int i = 0; i < win_count; i++)
			if (window[i] == seq) dup = 1'b1;
		dup = dup && (hdr[3] != regs.data_chunk_type);
		r.kind = lfd_pkg::KIND_FRAME;
		r.frame_version = hdr[2];
		r.frame_type = hdr[3];
		r.frame_flags = hdr[4];
		r.frame_seq = seq;
		r.frame_len = {hdr[8], hdr[7]};
		r.dup_flag = dup;
		if (!dup) begin
			if (seq_valid) begin
				diff = seq - prev_seq;
				if (diff == 0 || diff > 16'h8000) begin
					rec = 1'b0;
				end else if (diff > {1'b0, regs.wild_jump_limit}) begin
					win_count = 0;
					win_next = 0;
				end else if (diff > 1) begin
					r.seq_gap = (diff - 1 > 255) ? 8'd255 : 8'(diff - 1);
				end
			end
			if (rec) begin
				seq_valid = 1'b1;
				prev_seq = seq;
				window[win_next] = seq;
				win_next = (win_next + 1) % lfd_pkg::SEQ_WINDOW_DEPTH;
				if (win_count < lfd_pkg::SEQ_WINDOW_DEPTH) win_count++;
			end
		end
	endtask

	// advance the predicted state by one request
	task automatic predict_request(input lfd_pkg::in_item_t req);
		lfd_pkg::out_item_t r;
		logic [7:0]         b;
		logic [7:0]         saved [lfd_pkg::HEADER_BYTES - 2];
		int unsigned        flen;
		r = '0;
		b = req.link_byte;
		flen = {hdr[8], hdr[7]};
		if (req.func == lfd_pkg::FUNC_SESSION) begin
			seq_valid = 1'b0;
			prev_seq = '0;
			win_count = 0;
			win_next = 0;
		end else if (req.func == lfd_pkg::FUNC_RESYNC) begin
			framing_clear();
		end else if (req.func == lfd_pkg::FUNC_DATA) begin
			case (phase)
				PH_HUNT: hunt(b);
				PH_HEADER: begin
					hdr[nbytes] = b;
					nbytes++;
					crc = crc_step(crc, b);
					if (nbytes == lfd_pkg::HEADER_BYTES) begin
						flen = {hdr[8], hdr[7]};
						if (hdr[2] != regs.protocol_version || flen > regs.max_payload_len) begin
							r.kind = lfd_pkg::KIND_ERROR;
							r.error_code = (hdr[2] != regs.protocol_version) ?
								lfd_pkg::ERR_VERSION : lfd_pkg::ERR_LENGTH;
							expected_results.push_back(r);
							for (int i = 0; i < lfd_pkg::HEADER_BYTES - 2; i++)
								saved[i] = hdr[i + 2];
							framing_clear();
							// rescan the bytes after the magic
							for (int i = 0; i < lfd_pkg::HEADER_BYTES - 2; i++) begin
								if (phase == PH_HUNT) begin
									hunt(saved[i]);
								end else if (nbytes < lfd_pkg::HEADER_BYTES) begin
									hdr[nbytes] = saved[i];
									nbytes++;
									crc = crc_step(crc, saved[i]);
								end
							end
						end else begin
							trailer = '0;
							phase = (flen != 0) ? PH_PAYLOAD : PH_TRAILER;
						end
					end
				end
				PH_PAYLOAD: begin
					crc = crc_step(crc, b);
					nbytes++;
					if (nbytes >= lfd_pkg::HEADER_BYTES + flen) phase = PH_TRAILER;
					r.kind = lfd_pkg::KIND_PAYLOAD;
					r.payload_byte = b;
					expected_results.push_back(r);
				end
				default: begin
					trailer = trailer |
						({24'd0, b} << (8 * ((nbytes - lfd_pkg::HEADER_BYTES - flen) % 4)));
					nbytes++;
					if (nbytes >= lfd_pkg::HEADER_BYTES + flen + 4) begin
						if (~crc != trailer) begin
							r.kind = lfd_pkg::KIND_ERROR;
							r.error_code = lfd_pkg::ERR_CRC;
						end else begin
							track_frame(r);
						end
						expected_results.push_back(r);
						framing_clear();
					end
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lfd_pkg::out_item_t exp_r;
		if (!arst_n) begin
			regs <= '{8'd66, 8'd75, 8'd1, 16'd1024, 8'd0, 15'd1024};
			phase = PH_HUNT;
			got_first = 1'b0;
			nbytes = 0;
			crc = 32'hFFFFFFFF;
			trailer = '0;
			seq_valid = 1'b0;
			prev_seq = '0;
			win_count = 0;
			win_next = 0;
			fail_count <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					lfd_pkg::REG_MAGIC_FIRST:  regs.magic_first <= cfg_wdata[7:0];
					lfd_pkg::REG_MAGIC_SECOND: regs.magic_second <= cfg_wdata[7:0];
					lfd_pkg::REG_VERSION:      regs.protocol_version <= cfg_wdata[7:0];
					lfd_pkg::REG_MAX_LEN:      regs.max_payload_len <= cfg_wdata;
					lfd_pkg::REG_DATA_TYPE:    regs.data_chunk_type <= cfg_wdata[7:0];
					lfd_pkg::REG_JUMP_LIMIT:   regs.wild_jump_limit <= cfg_wdata[14:0];
					default: ;
				endcase
			end
			// compare result
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %p", out_data);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r !== out_data) begin
						if (fail_count < 10)
							$display("result differs: expected %p actual %p", exp_r, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				predict_request(in_data);
		end
	end
endmodule

`default_nettype wire

// ===== sim/link_frame_deframer_seq_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_frame_deframer_seq_tracker_tb: stimulus and verdict for the deframer
// Sends directed and random framed byte streams through several register
// settings with random idle bursts; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module link_frame_deframer_seq_tracker_tb;

	localparam int WATCHDOG_LIMIT = 20000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	lfd_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	lfd_pkg::out_item_t out_data;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_wdata = '0;
	int                 fail_count;
	int                 pending;
	int                 idle_cycles;
	bit                 calm = 1'b0;
	int                 sent = 0;
	logic [7:0] mag1 = 8'd66, mag2 = 8'd75, ver = 8'd1, dtype = 8'd0;
	logic [15:0] maxlen = 16'd1024;
	logic [15:0] seq_base = 16'd0;

	link_frame_deframer_seq_tracker dut (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
		.out_data, .cfg_we, .cfg_index, .cfg_wdata
	);

	lfd_checker checker_i (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
		.out_data, .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("link_frame_deframer_seq_tracker: mismatch");
			$finish;
		end
	end

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (calm || $urandom_range(0, 5) != 0)
			out_ready <= 1'b1;
		else begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			out_ready <= 1'b1;
		end
	end

	// one request, with an occasional idle burst ahead of it
	task automatic send_req(input logic [1:0] f, input logic [7:0] b);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{f, b};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_req(lfd_pkg::FUNC_DATA, b);
	endtask

	// crc over a byte list, final xor included
	function automatic logic [31:0] crc_of(input logic [7:0] bytes [$]);
		logic [31:0] c;
		c = 32'hFFFFFFFF;
		foreach (bytes[i]) c = lfd_pkg::crc_byte(c, bytes[i]);
		return ~c;
	endfunction

	// header only, for headers that are rejected
	task automatic send_header(input logic [7:0] v, input logic [7:0] t, input logic [7:0] fl,
			input logic [15:0] sq, input logic [15:0] len);
		logic [7:0] bytes [$];
		bytes = {mag1, mag2, v, t, fl, sq[7:0], sq[15:8], len[7:0], len[15:8]};
		foreach (bytes[i]) send_byte(bytes[i]);
	endtask

	// full frame; bad_crc flips a trailer bit
	task automatic send_frame(input logic [7:0] v, input logic [7:0] t, input logic [7:0] fl,
			input logic [15:0] sq, input logic [15:0] len, input bit bad_crc);
		logic [7:0]  bytes [$];
		logic [31:0] c;
		bytes = {mag1, mag2, v, t, fl, sq[7:0], sq[15:8], len[7:0], len[15:8]};
		for (int i = 0; i < len; i++) bytes.push_back(8'($urandom));
		c = crc_of(bytes);
		if (bad_crc) c[$urandom_range(0, 31)] ^= 1'b1;
		foreach (bytes[i]) send_byte(bytes[i]);
		for (int i = 0; i < 4; i++) send_byte(c[8 * i +: 8]);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(input logic [7:0] m1, input logic [7:0] m2,
			input logic [7:0] v, input logic [15:0] ml, input logic [7:0] dt,
			input logic [14:0] jl);
		drain();
		write_reg(lfd_pkg::REG_MAGIC_FIRST, m1);
		write_reg(lfd_pkg::REG_MAGIC_SECOND, m2);
		write_reg(lfd_pkg::REG_VERSION, v);
		write_reg(lfd_pkg::REG_MAX_LEN, ml);
		write_reg(lfd_pkg::REG_DATA_TYPE, dt);
		write_reg(lfd_pkg::REG_JUMP_LIMIT, jl);
		mag1 = m1; mag2 = m2; ver = v; maxlen = ml; dtype = dt;
		@(posedge clk);
	endtask

	// random mix: mostly well-formed frames with random content
	task automatic random_phase(input int count);
		int          pick;
		logic [15:0] len, sq;
		logic [15:0] cap;
		int          stop_at;
		stop_at = sent + count;
		while (sent < stop_at) begin
			pick = $urandom_range(0, 99);
			cap = (maxlen > 12) ? 16'd12 : maxlen;
			len = $urandom_range(0, cap);
			case ($urandom_range(0, 5))
				0: sq = seq_base;
				1: sq = seq_base - $urandom_range(1, 9);
				2: sq = 16'($urandom);
				3: sq = seq_base + $urandom_range(2, 300);
				default: sq = seq_base + 1;
			endcase
			if (pick < 65) begin
				send_frame(ver, ($urandom_range(0, 3) == 0) ? dtype : 8'($urandom),
					8'($urandom), sq, len, $urandom_range(0, 9) == 0);
				seq_base = sq;
			end else if (pick < 72) begin
				send_frame(ver ^ 8'(1 << $urandom_range(0, 7)), 8'($urandom), 8'($urandom),
					sq, len, 1'b0);
			end else if (pick < 77 && maxlen != 16'hFFFF) begin
				send_header(ver, 8'($urandom), 8'($urandom), sq,
					maxlen + $urandom_range(1, 3));
			end else if (pick < 85) begin
				send_byte(mag1);
				for (int i = 0; i < $urandom_range(1, 12); i++)
					send_byte(($urandom_range(0, 3) == 0) ? mag2 : 8'($urandom));
			end else if (pick < 90) begin
				send_req(lfd_pkg::FUNC_SESSION, 8'($urandom));
			end else if (pick < 95) begin
				send_req(lfd_pkg::FUNC_RESYNC, 8'($urandom));
			end else if (pick < 97) begin
				send_req(2'd3, 8'($urandom));
			end else begin
				send_byte(8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults
		send_req(lfd_pkg::FUNC_SESSION, 8'h00);
		send_frame(8'd1, 8'd5, 8'hFF, 16'd10, 16'd0, 1'b0);
		send_frame(8'd1, 8'd5, 8'h00, 16'd10, 16'd1, 1'b0);
		send_frame(8'd1, 8'd7, 8'hA5, 16'd13, 16'd2, 1'b1);
		send_frame(8'd1, 8'd0, 8'h5A, 16'd10, 16'd0, 1'b0);
		send_frame(8'd1, 8'd9, 8'h01, 16'd9000, 16'd0, 1'b0);
		send_frame(8'd1, 8'd9, 8'h01, 16'd8000, 16'd0, 1'b0);
		send_header(8'd2, 8'd1, 8'd1, 16'd1, 16'd2000);
		send_header(8'd1, 8'd1, 8'd1, 16'd1, 16'd1025);
		// rescan finds a magic inside a bad header
		send_header(8'd66, 8'd75, 8'd1, 16'hFFFF, 16'hFFFF);
		send_req(lfd_pkg::FUNC_RESYNC, 8'hFF);
		send_req(2'd3, 8'hFF);
		send_frame(8'd1, 8'd3, 8'd3, 16'hFFFF, 16'd3, 1'b0);

		apply_settings(8'h00, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 15'd1);
		random_phase(300);
		apply_settings(8'hFF, 8'h00, 8'h00, 16'd0, 8'h00, 15'h7FFF);
		random_phase(250);
		// equal magic bytes never leave hunt
		apply_settings(8'h5A, 8'h5A, 8'h01, 16'd8, 8'h10, 15'd40);
		random_phase(80);
		apply_settings(8'hA5, 8'h3C, 8'h81, 16'd6, 8'h10, 15'd40);
		random_phase(300);
		calm = 1'b1;
		apply_settings(8'd66, 8'd75, 8'd1, 16'd1024, 8'd0, 15'd1024);
		random_phase(300);
		drain();

		if (fail_count == 0)
			$display("link_frame_deframer_seq_tracker: match");
		else
			$display("link_frame_deframer_seq_tracker: mismatch");
		$finish;
	end
endmodule

`default_nettype wire
